// ===== src/scd_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the stereo chorus delay.
// No dependencies; scd_cfg_if, scd_lfo, scd_lane and the top level import this package.
package scd_pkg;

	// Configuration port widths.
	localparam int CFG_INDEX_BITS = 4;
	localparam int CFG_DATA_BITS  = 32;

	// Register indexes on the configuration port.
	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_BASE_DELAY    = 4'd0,
		REG_MOD_DEPTH     = 4'd1,
		REG_FEEDBACK_GAIN = 4'd2,
		REG_PHASE_STEP    = 4'd3
	} cfg_reg_t;

	// Register reset values.
	localparam logic [18:0] BASE_DELAY_RST    = 19'd5120;
	localparam logic [15:0] MOD_DEPTH_RST     = 16'd16384;
	localparam logic [15:0] FEEDBACK_GAIN_RST = 16'd0;
	localparam logic [31:0] PHASE_STEP_RST    = 32'd4473924;

	// Sine generation constants in Q28.
	localparam logic [63:0] PI_Q28      = 64'd843314857;
	localparam logic [63:0] HALF_PI_Q28 = 64'd421657428;
	localparam logic [63:0] TWO_PI_Q28  = 64'd1686629713;
	localparam logic [63:0] ONE_Q28     = 64'd268435456;

	// Taylor series divisors (2n)(2n+1) for n = 1..6.
	localparam logic [7:0] TAYLOR_DIV [6] = '{8'd6, 8'd20, 8'd42, 8'd72, 8'd110, 8'd156};

	// Right channel delay scale, 1.07 in Q15.
	localparam logic [15:0] RIGHT_SCALE = 16'd35062;

	// Cycles from a phase or register change until the delays are valid.
	localparam logic [2:0] LFO_LATENCY = 3'd4;

	// Per-step strobes from the sequencer to both channel lanes.
	typedef struct packed {
		logic load;
		logic rd_next;
		logic mac_a;
		logic mac_b;
		logic fb;
		logic wr;
		logic clr;
	} scd_lane_ctrl_t;

endpackage

// ===== src/scd_in_if.sv =====
`timescale 1ns / 1ps
// Input frame channel: valid/ready handshake with one stereo sample pair.
// Standalone; sample width is set by its parameter.
interface scd_in_if #(parameter int SAMPLE_BITS = 24) ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] left_in;
	logic signed [SAMPLE_BITS-1:0] right_in;

	modport source (output valid, output left_in, output right_in, input ready);
	modport sink   (input valid, input left_in, input right_in, output ready);
endinterface

// ===== src/scd_out_if.sv =====
`timescale 1ns / 1ps
// Result channel: valid/ready handshake with one delayed stereo sample pair.
// Standalone; sample width is set by its parameter.
interface scd_out_if #(parameter int SAMPLE_BITS = 24) ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] left_out;
	logic signed [SAMPLE_BITS-1:0] right_out;

	modport source (output valid, output left_out, output right_out, input ready);
	modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

// ===== src/scd_cfg_if.sv =====
`timescale 1ns / 1ps
// Configuration write channel: register index and write data with valid/ready.
// Depends on scd_pkg for the field widths.
interface scd_cfg_if import scd_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [CFG_INDEX_BITS-1:0] index;
	logic [CFG_DATA_BITS-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/scd_ram.sv =====
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module scd_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== src/scd_lfo.sv =====
`timescale 1ns / 1ps
// LFO phase accumulator, sine table and delay computation for both channels.
// Depends on scd_pkg; the settled output shows when the delays are valid after a change.
module scd_lfo import scd_pkg::*; #(
	parameter int LINE_DEPTH   = 4096,
	parameter int SINE_ENTRIES = 1024
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            advance,
	input  logic                            cfg_change,
	input  logic [31:0]                     phase_step,
	input  logic [18:0]                     base_delay,
	input  logic [15:0]                     mod_depth,
	output logic                            settled,
	output logic [$clog2(LINE_DEPTH)+8:0]   left_delay,
	output logic [$clog2(LINE_DEPTH)+8:0]   right_delay
);

	localparam int AW = $clog2(LINE_DEPTH);
	localparam int DW = AW + 9;
	localparam int SW = $clog2(SINE_ENTRIES);
	localparam int CW = (DW > 22) ? DW : 22;
	localparam logic [CW-1:0] LIMIT = CW'(LINE_DEPTH) << 8;

	typedef logic [15:0] rom_t [SINE_ENTRIES];

	// LFO value per table entry: 16384 +/- rounded 16384*sin, quarter-wave reduced.
	function automatic rom_t build_rom();
		rom_t               r;
		logic [63:0]        a;
		logic [63:0]        x2;
		logic [63:0]        term;
		logic signed [63:0] s;
		logic [63:0]        q;
		logic               neg;
		for (int k = 0; k < SINE_ENTRIES; k++) begin
			a = 64'(k) * TWO_PI_Q28 / 64'(SINE_ENTRIES);
			neg = 1'b0;
			if (a >= PI_Q28) begin
				neg = 1'b1;
				a = a - PI_Q28;
			end
			if (a > HALF_PI_Q28) begin
				a = (a <= PI_Q28) ? PI_Q28 - a : 64'd0;
			end
			x2 = (a * a) >> 28;
			term = a;
			s = $signed(a);
			for (int n = 1; n <= 6; n++) begin
				term = ((term * x2) >> 28) / 64'(TAYLOR_DIV[n-1]);
				if (n % 2 == 1) begin
					s = s - $signed(term);
				end else begin
					s = s + $signed(term);
				end
			end
			if (s < 0) begin
				s = 64'sd0;
			end
			if (s > $signed(ONE_Q28)) begin
				s = $signed(ONE_Q28);
			end
			q = ($unsigned(s) + 64'd8192) >> 14;
			r[k] = neg ? 16'(64'd16384 - q) : 16'(64'd16384 + q);
		end
		return r;
	endfunction

	localparam rom_t LFO_ROM = build_rom();

	logic [31:0]   phase_q;
	logic [2:0]    settle_q;
	logic [15:0]   lfo_s1;
	logic [16:0]   fac_s2;
	logic [20:0]   dl_s3;
	logic [DW-1:0] dl_s4;
	logic [DW-1:0] dr_s4;
	logic [31:0]   depth_prod;
	logic [35:0]   base_prod;
	logic [36:0]   right_prod;
	logic [CW-1:0] dl_wide;
	logic [CW-1:0] dr_wide;

	// Phase accumulator and settle counter; any change restarts the count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= '0;
			settle_q <= '0;
		end else begin
			if (advance) begin
				phase_q <= phase_q + phase_step;
			end
			if (advance || cfg_change) begin
				settle_q <= '0;
			end else if (settle_q != LFO_LATENCY) begin
				settle_q <= settle_q + 3'd1;
			end
		end
	end

	assign settled = (settle_q == LFO_LATENCY);

	// Delay arithmetic, at most one multiplier per stage.
	assign depth_prod = 32'(mod_depth) * 32'(lfo_s1);
	assign base_prod  = 36'(base_delay) * 36'(fac_s2);
	assign right_prod = 37'(dl_s3) * 37'(RIGHT_SCALE);
	assign dl_wide    = CW'(dl_s3);
	assign dr_wide    = CW'(right_prod[36:15]);

	// Table read, depth scaling, base scaling, then right scaling and saturation of both delays.
	always_ff @(posedge clk) begin
		lfo_s1 <= LFO_ROM[phase_q[31 -: SW]];
		fac_s2 <= 17'(depth_prod >> 15) + 17'd32768;
		dl_s3  <= base_prod[35:15];
		dl_s4  <= (dl_wide > LIMIT) ? DW'(LIMIT) : DW'(dl_wide);
		dr_s4  <= (dr_wide > LIMIT) ? DW'(LIMIT) : DW'(dr_wide);
	end

	assign left_delay  = dl_s4;
	assign right_delay = dr_s4;

endmodule

// ===== src/scd_lane.sv =====
`timescale 1ns / 1ps
// One channel lane: delay line RAM, interpolated read, feedback and saturated write.
// Depends on scd_pkg and scd_ram; stepped by the sequencer in the top level.
module scd_lane import scd_pkg::*; #(
	parameter int LINE_DEPTH  = 4096,
	parameter int SAMPLE_BITS = 24
) (
	input  logic                          clk,
	input  scd_lane_ctrl_t                ctrl,
	input  logic [$clog2(LINE_DEPTH)-1:0] wp,
	input  logic [$clog2(LINE_DEPTH)-1:0] clr_addr,
	input  logic [$clog2(LINE_DEPTH)+8:0] delay,
	input  logic signed [SAMPLE_BITS-1:0] sample_in,
	input  logic signed [15:0]            gain,
	output logic signed [SAMPLE_BITS-1:0] delayed
);

	localparam int AW = $clog2(LINE_DEPTH);
	localparam int DW = AW + 9;
	localparam int SB = SAMPLE_BITS;
	localparam logic signed [SB-1:0] S_MAX = {1'b0, {(SB-1){1'b1}}};
	localparam logic signed [SB-1:0] S_MIN = {1'b1, {(SB-1){1'b0}}};

	logic [DW-1:0]          delay_q;
	logic signed [SB-1:0]   in_q;
	logic [AW+7:0]          pos;
	logic [AW-1:0]          base_addr;
	logic [AW-1:0]          next_addr;
	logic [7:0]             frac;
	logic [8:0]             wgt_a;
	logic [AW-1:0]          raddr;
	logic [SB-1:0]          rdata;
	logic signed [SB+9:0]   pa_q;
	logic signed [SB+10:0]  acc;
	logic signed [SB-1:0]   d_q;
	logic signed [SB+15:0]  fbp_q;
	logic [SB+16:0]         fbr;
	logic signed [SB+2:0]   sum;
	logic [3:0]             sum_top;
	logic signed [SB-1:0]   wr_sample;
	logic                   we;
	logic [AW-1:0]          waddr;
	logic [SB-1:0]          wdata;

	// Read position behind the write pointer; the line depth wraps out of the subtraction.
	assign pos       = {wp, 8'd0} - delay_q[AW+7:0];
	assign base_addr = pos[AW+7:8];
	assign frac      = pos[7:0];
	assign next_addr = base_addr + AW'(1);
	assign wgt_a     = 9'd256 - {1'b0, frac};
	assign raddr     = ctrl.rd_next ? next_addr : base_addr;

	// Second interpolation product plus rounding.
	assign acc = (SB+11)'(pa_q)
		+ (SB+11)'($signed(rdata) * $signed({1'b0, frac}))
		+ (SB+11)'(128);

	// Feedback term rounded from Q15, added to the input and saturated.
	assign fbr     = (SB+17)'(fbp_q) + (SB+17)'(17'd16384);
	assign sum     = (SB+3)'(in_q) + (SB+3)'($signed(fbr[SB+16:15]));
	assign sum_top = sum[SB+2:SB-1];
	always_comb begin
		if ((&sum_top) || !(|sum_top)) begin
			wr_sample = sum[SB-1:0];
		end else begin
			wr_sample = sum[SB+2] ? S_MIN : S_MAX;
		end
	end

	// The clearing pass and the item write share the RAM write port.
	assign we    = ctrl.wr || ctrl.clr;
	assign waddr = ctrl.clr ? clr_addr : wp;
	assign wdata = ctrl.clr ? '0 : wr_sample;

	scd_ram #(.WIDTH(SB), .DEPTH(LINE_DEPTH)) u_line (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Datapath registers, each loaded on its sequencer step.
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			delay_q <= delay;
			in_q    <= sample_in;
		end
		if (ctrl.mac_a) begin
			pa_q <= $signed(rdata) * $signed({1'b0, wgt_a});
		end
		if (ctrl.mac_b) begin
			d_q <= acc[SB+7:8];
		end
		if (ctrl.fb) begin
			fbp_q <= d_q * gain;
		end
	end

	assign delayed = d_q;

endmodule

// ===== src/stereo_chorus_delay.sv =====
`timescale 1ns / 1ps
// Stereo chorus delay: LFO-modulated delay lines with feedback, fully wet output.
// Depends on scd_pkg, the three channel interfaces, scd_lfo, scd_lane and scd_ram.
//
// Usage:
//   frame   - input items, one stereo sample pair each (valid/ready).
//   delayed - result items, one delayed interpolated pair per input item.
//   regs    - register writes (index, data); always ready, write only when idle.
// An accepted item steps the sequencer through RD0, RD1, MAC, FB and WR, then
// the result register loads. The steps cover two reads per channel through the
// single read port of the line RAM, an interpolation multiply-add, a feedback
// multiply and the write-back. Both channels run in parallel lanes. A new item
// is taken only back in idle; the four-stage delay pipeline refills during the
// item, and after a register write the frame channel stays low while it refills.
// After reset both delay lines are cleared one entry per cycle, all LINE_DEPTH
// entries, before the first item is taken; register writes are taken throughout.
// The result register frees the lanes: a new item is accepted while a result
// waits. If the receiver stalls with a result still pending when the next one
// is done, that item holds in the lanes until the result register frees.
module stereo_chorus_delay import scd_pkg::*; #(
	parameter int LINE_DEPTH   = 4096,
	parameter int SINE_ENTRIES = 1024,
	parameter int SAMPLE_BITS  = 24
) (
	input  logic         clk,
	input  logic         arst_n,
	scd_in_if.sink       frame,
	scd_out_if.source    delayed,
	scd_cfg_if.sink      regs
);

	localparam int AW = $clog2(LINE_DEPTH);
	localparam int DW = AW + 9;
	localparam int SB = SAMPLE_BITS;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD0,
		ST_RD1,
		ST_MAC,
		ST_FB,
		ST_WR,
		ST_HOLD
	} state_t;

	state_t               state_q;
	logic [AW-1:0]        wp_q;
	logic                 clr_busy_q;
	logic [AW-1:0]        clr_addr_q;
	logic                 res_valid_q;
	logic signed [SB-1:0] left_out_q;
	logic signed [SB-1:0] right_out_q;
	logic [18:0]          base_delay_q;
	logic [15:0]          mod_depth_q;
	logic signed [15:0]   feedback_gain_q;
	logic [31:0]          phase_step_q;
	logic                 accept;
	logic                 cfg_write;
	logic                 res_free;
	logic                 res_load;
	logic                 settled;
	logic [DW-1:0]        left_delay;
	logic [DW-1:0]        right_delay;
	logic signed [SB-1:0] left_d;
	logic signed [SB-1:0] right_d;
	scd_lane_ctrl_t       lane_ctrl;

	assign accept    = frame.valid && frame.ready;
	assign cfg_write = regs.valid && regs.ready;
	assign res_free  = !res_valid_q || delayed.ready;
	assign res_load  = ((state_q == ST_WR) || (state_q == ST_HOLD)) && res_free;

	assign frame.ready = (state_q == ST_IDLE) && !clr_busy_q && settled;
	assign regs.ready  = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_delay_q    <= BASE_DELAY_RST;
			mod_depth_q     <= MOD_DEPTH_RST;
			feedback_gain_q <= FEEDBACK_GAIN_RST;
			phase_step_q    <= PHASE_STEP_RST;
		end else if (cfg_write) begin
			unique case (cfg_reg_t'(regs.index))
				REG_BASE_DELAY:    base_delay_q    <= regs.data[18:0];
				REG_MOD_DEPTH:     mod_depth_q     <= regs.data[15:0];
				REG_FEEDBACK_GAIN: feedback_gain_q <= $signed(regs.data[15:0]);
				REG_PHASE_STEP:    phase_step_q    <= regs.data;
				default: ;
			endcase
		end
	end

	// Lane step strobes decoded from the sequencer state.
	always_comb begin
		lane_ctrl         = '0;
		lane_ctrl.load    = accept;
		lane_ctrl.rd_next = (state_q == ST_RD1);
		lane_ctrl.mac_a   = (state_q == ST_RD1);
		lane_ctrl.mac_b   = (state_q == ST_MAC);
		lane_ctrl.fb      = (state_q == ST_FB);
		lane_ctrl.wr      = (state_q == ST_WR);
		lane_ctrl.clr     = clr_busy_q;
	end

	// Sequencer, write pointer, clearing pass and merged result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			wp_q        <= '0;
			clr_busy_q  <= 1'b1;
			clr_addr_q  <= '0;
			res_valid_q <= 1'b0;
			left_out_q  <= '0;
			right_out_q <= '0;
		end else begin
			if (clr_busy_q) begin
				clr_addr_q <= clr_addr_q + AW'(1);
				if (&clr_addr_q) begin
					clr_busy_q <= 1'b0;
				end
			end
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (delayed.ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_RD0;
					end
				end
				ST_RD0: state_q <= ST_RD1;
				ST_RD1: state_q <= ST_MAC;
				ST_MAC: state_q <= ST_FB;
				ST_FB:  state_q <= ST_WR;
				ST_WR: begin
					wp_q <= wp_q + AW'(1);
					if (res_free) begin
						left_out_q  <= left_d;
						right_out_q <= right_d;
						state_q     <= ST_IDLE;
					end else begin
						state_q <= ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (res_free) begin
						left_out_q  <= left_d;
						right_out_q <= right_d;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign delayed.valid     = res_valid_q;
	assign delayed.left_out  = left_out_q;
	assign delayed.right_out = right_out_q;

	scd_lfo #(.LINE_DEPTH(LINE_DEPTH), .SINE_ENTRIES(SINE_ENTRIES)) u_lfo (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (accept),
		.cfg_change  (cfg_write),
		.phase_step  (phase_step_q),
		.base_delay  (base_delay_q),
		.mod_depth   (mod_depth_q),
		.settled     (settled),
		.left_delay  (left_delay),
		.right_delay (right_delay)
	);

	scd_lane #(.LINE_DEPTH(LINE_DEPTH), .SAMPLE_BITS(SAMPLE_BITS)) u_left (
		.clk       (clk),
		.ctrl      (lane_ctrl),
		.wp        (wp_q),
		.clr_addr  (clr_addr_q),
		.delay     (left_delay),
		.sample_in (frame.left_in),
		.gain      (feedback_gain_q),
		.delayed   (left_d)
	);

	scd_lane #(.LINE_DEPTH(LINE_DEPTH), .SAMPLE_BITS(SAMPLE_BITS)) u_right (
		.clk       (clk),
		.ctrl      (lane_ctrl),
		.wp        (wp_q),
		.clr_addr  (clr_addr_q),
		.delay     (right_delay),
		.sample_in (frame.right_in),
		.gain      (feedback_gain_q),
		.delayed   (right_d)
	);

	// No item is taken during the clearing pass or with unsettled delays.
	a_accept_ok: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> (!clr_busy_q && settled))
		else $error("item accepted while clearing or with unsettled delays");

	// The write pointer moves only on the write-back step.
	a_wp_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_WR) |=> $stable(wp_q))
		else $error("write pointer moved outside the write-back step");

	// A pending result under stall keeps the finished item held in the lanes.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_HOLD && res_valid_q && !delayed.ready)
		|=> (state_q == ST_HOLD && $stable(left_out_q) && $stable(right_out_q)))
		else $error("result overwritten while the receiver stalls");

endmodule
